/* hdl/infix_to_postfix_converter_unit_macros.svh */
// ============================================================================
// Assertion macros for the infix to postfix converter
// Shared property forms, clocked on clk and disabled while rst is high.
// ============================================================================
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/itp_pkg.sv */
// ============================================================================
// itp_pkg
// Shared constants, codes, command and status types for the converter.
// ============================================================================
`timescale 1ns / 1ps

package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SYM_W       = 8;

  localparam logic [SYM_W-1:0] CHAR_POW    = 8'h5E;
  localparam logic [SYM_W-1:0] CHAR_MUL    = 8'h2A;
  localparam logic [SYM_W-1:0] CHAR_DIV    = 8'h2F;
  localparam logic [SYM_W-1:0] CHAR_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CHAR_RPAREN = 8'h29;
  localparam logic [SYM_W-1:0] CHAR_A      = 8'h41;
  localparam logic [SYM_W-1:0] CHAR_Z      = 8'h5A;
  localparam logic [SYM_W-1:0] CHAR_NUL    = 8'h00;

  typedef enum logic [2:0] {
    OPC_LPAREN = 3'd0,
    OPC_PLUS   = 3'd1,
    OPC_MINUS  = 3'd2,
    OPC_MUL    = 3'd3,
    OPC_DIV    = 3'd4,
    OPC_POW    = 3'd5
  } op_code_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_code_t;

  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OP,
    CLS_OTHER
  } sym_class_t;

  typedef enum logic [1:0] {
    EMIT_SYM,
    EMIT_TOP,
    EMIT_OVERFLOW,
    EMIT_UNMATCHED
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    emit_sel_t emit_sel;
    logic      push;
    logic      pop;
    logic      rd;
    logic      close;
  } dp_cmd_t;

  typedef struct packed {
    sym_class_t cls;
    logic       end_flag;
    logic       count_zero;
    logic       count_one;
    logic       full;
    logic       top_is_lp;
    logic       top_ge;
    logic       pend_valid;
    logic       out_free;
  } dp_status_t;

  function automatic sym_class_t classify(input logic [SYM_W-1:0] sym);
    sym_class_t cls;
    priority if (sym >= CHAR_A && sym <= CHAR_Z) begin
      cls = CLS_LETTER;
    end else if (sym == CHAR_LPAREN) begin
      cls = CLS_LPAREN;
    end else if (sym == CHAR_RPAREN) begin
      cls = CLS_RPAREN;
    end else if (sym == CHAR_PLUS || sym == CHAR_MINUS || sym == CHAR_MUL ||
                 sym == CHAR_DIV || sym == CHAR_POW) begin
      cls = CLS_OP;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  function automatic op_code_t sym_to_code(input logic [SYM_W-1:0] sym);
    op_code_t code;
    case (sym)
      CHAR_PLUS:  code = OPC_PLUS;
      CHAR_MINUS: code = OPC_MINUS;
      CHAR_MUL:   code = OPC_MUL;
      CHAR_DIV:   code = OPC_DIV;
      CHAR_POW:   code = OPC_POW;
      default:    code = OPC_LPAREN;
    endcase
    return code;
  endfunction

  function automatic logic [SYM_W-1:0] code_to_char(input op_code_t code);
    logic [SYM_W-1:0] ch;
    case (code)
      OPC_LPAREN: ch = CHAR_LPAREN;
      OPC_PLUS:   ch = CHAR_PLUS;
      OPC_MINUS:  ch = CHAR_MINUS;
      OPC_MUL:    ch = CHAR_MUL;
      OPC_DIV:    ch = CHAR_DIV;
      OPC_POW:    ch = CHAR_POW;
      default:    ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(input op_code_t code);
    logic [1:0] prec;
    case (code)
      OPC_PLUS, OPC_MINUS: prec = 2'd1;
      OPC_MUL, OPC_DIV:    prec = 2'd2;
      OPC_POW:             prec = 2'd3;
      default:             prec = 2'd0;
    endcase
    return prec;
  endfunction

endpackage

/* hdl/itp_datapath.sv */
// ============================================================================
// itp_datapath
// Input holding register, operator stack memory, stack count, pending result
// slot and output register.
// ============================================================================
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_unit_macros.svh"

module itp_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  itp_pkg::dp_cmd_t       cmd,
  output itp_pkg::dp_status_t    status,
  input  logic [itp_pkg::SYM_W-1:0] s_tdata,  // symbol
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [itp_pkg::SYM_W-1:0] m_tdata,  // out_symbol
  output logic                   m_tlast,
  output logic [2:0]             m_tuser      // has_symbol, error_code[1:0]
);
  import itp_pkg::*;

  logic [SYM_W-1:0] sym_reg;
  logic             end_reg;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_m1;
  op_code_t         stack_mem [STACK_DEPTH];
  op_code_t         top;

  logic             pend_valid;
  logic [SYM_W-1:0] pend_sym;
  logic             pend_has;
  err_code_t        pend_err;

  logic             out_valid;
  logic [SYM_W-1:0] out_sym;
  logic             out_has;
  logic             out_last;
  err_code_t        out_err;

  logic             out_free;
  logic             load;
  logic [SYM_W-1:0] load_sym;
  logic             load_has;
  logic             load_last;
  err_code_t        load_err;
  logic [SYM_W-1:0] new_sym;
  logic             new_has;
  err_code_t        new_err;

  assign count_m1 = count - 1'b1;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    unique case (cmd.emit_sel)
      EMIT_SYM: begin
        new_sym = sym_reg;
        new_has = 1'b1;
        new_err = ERR_NONE;
      end
      EMIT_TOP: begin
        new_sym = code_to_char(top);
        new_has = 1'b1;
        new_err = ERR_NONE;
      end
      EMIT_OVERFLOW: begin
        new_sym = CHAR_NUL;
        new_has = 1'b0;
        new_err = ERR_OVERFLOW;
      end
      EMIT_UNMATCHED: begin
        new_sym = CHAR_NUL;
        new_has = 1'b0;
        new_err = ERR_UNMATCHED;
      end
    endcase
  end

  // A new result pushes the pending one out; closing an item releases the
  // pending result, or a bare end marker when the item ended with none.
  always_comb begin
    load      = 1'b0;
    load_sym  = pend_sym;
    load_has  = pend_has;
    load_err  = pend_err;
    load_last = 1'b0;
    if (cmd.emit && pend_valid) begin
      load = 1'b1;
    end else if (cmd.close) begin
      if (pend_valid) begin
        load      = 1'b1;
        load_last = end_reg;
      end else if (end_reg) begin
        load      = 1'b1;
        load_sym  = CHAR_NUL;
        load_has  = 1'b0;
        load_err  = ERR_NONE;
        load_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_reg <= s_tdata;
      end_reg <= s_tlast;
    end
    if (cmd.push) begin
      stack_mem[count[ADDR_W-1:0]] <= sym_to_code(sym_reg);
    end
    if (cmd.rd) begin
      top <= stack_mem[count_m1[ADDR_W-1:0]];
    end
    if (cmd.emit) begin
      pend_sym <= new_sym;
      pend_has <= new_has;
      pend_err <= new_err;
    end
    if (load) begin
      out_sym  <= load_sym;
      out_has  <= load_has;
      out_err  <= load_err;
      out_last <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.push) begin
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        count <= count_m1;
      end
      if (cmd.emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.close) begin
        pend_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.cls        = classify(sym_reg);
  assign status.end_flag   = end_reg;
  assign status.count_zero = (count == '0);
  assign status.count_one  = (count == CNT_W'(1));
  assign status.full       = (count == CNT_W'(STACK_DEPTH));
  assign status.top_is_lp  = (top == OPC_LPAREN);
  assign status.top_ge     = (code_prec(top) >= code_prec(sym_to_code(sym_reg)));
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_sym;
  assign m_tlast  = out_last;
  assign m_tuser  = {out_err, out_has};

  `ITP_ASSERT_NOW(a_no_overrun, load, out_free, "Output register overwritten before taken.")
  `ITP_ASSERT_NOW(a_push_room, cmd.push, !status.full, "Push issued on a full stack.")
  `ITP_ASSERT_NOW(a_pop_nonempty, cmd.pop || cmd.rd, !status.count_zero, "Pop on empty stack.")
  `ITP_ASSERT_NEXT(a_emit_reaches_out, cmd.emit && pend_valid, out_valid, "Result lost.")

endmodule

/* hdl/itp_ctrl.sv */
// ============================================================================
// itp_ctrl
// Sequencer that walks one input character through decode, stack pops,
// push and result release.
// ============================================================================
`timescale 1ns / 1ps

module itp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  itp_pkg::dp_status_t status,
  output itp_pkg::dp_cmd_t    cmd
);
  import itp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_EVAL,
    ST_ERR2,
    ST_PUSH,
    ST_FINISH,
    ST_CLOSE
  } state_t;

  typedef enum logic [1:0] {
    MODE_RPAREN,
    MODE_OP,
    MODE_FLUSH
  } mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;
  logic   stall;

  assign stall    = status.pend_valid && !status.out_free;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    mode_next    = mode;
    cmd          = '0;
    cmd.emit_sel = EMIT_SYM;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status.cls)
          CLS_LETTER: begin
            if (!stall) begin
              cmd.emit   = 1'b1;
              state_next = ST_FINISH;
            end
          end
          CLS_LPAREN: state_next = ST_PUSH;
          CLS_RPAREN: begin
            mode_next  = MODE_RPAREN;
            state_next = status.count_zero ? ST_ERR2 : ST_READ;
          end
          CLS_OP: begin
            mode_next  = MODE_OP;
            state_next = status.count_zero ? ST_PUSH : ST_READ;
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (!stall) begin
          cmd.emit_sel = EMIT_TOP;
          unique case (mode)
            MODE_RPAREN: begin
              cmd.pop = 1'b1;
              if (status.top_is_lp) begin
                state_next = ST_FINISH;
              end else begin
                cmd.emit   = 1'b1;
                state_next = status.count_one ? ST_ERR2 : ST_READ;
              end
            end
            MODE_OP: begin
              if (status.top_is_lp || !status.top_ge) begin
                state_next = ST_PUSH;
              end else begin
                cmd.pop    = 1'b1;
                cmd.emit   = 1'b1;
                state_next = status.count_one ? ST_PUSH : ST_READ;
              end
            end
            default: begin
              cmd.pop    = 1'b1;
              cmd.emit   = !status.top_is_lp;
              state_next = status.count_one ? ST_CLOSE : ST_READ;
            end
          endcase
        end
      end
      ST_ERR2: begin
        if (!stall) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_UNMATCHED;
          state_next   = ST_FINISH;
        end
      end
      ST_PUSH: begin
        if (!stall) begin
          cmd.emit_sel = EMIT_OVERFLOW;
          cmd.emit     = status.full;
          cmd.push     = !status.full;
          state_next   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.end_flag && !status.count_zero) begin
          mode_next  = MODE_FLUSH;
          state_next = ST_READ;
        end else begin
          state_next = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (status.out_free) begin
          cmd.close  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode  <= MODE_FLUSH;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

endmodule

/* hdl/infix_to_postfix_converter_unit.sv */
// ============================================================================
// infix_to_postfix_converter_unit
// Shunting-yard converter: takes infix characters, emits postfix characters.
//
// Channel  Dir  tdata            tuser                          tlast
// s_*      in   [7:0] symbol     -                              end_of_expr
// m_*      out  [7:0] out_symbol [0] has_symbol, [2:1] error_code  is_last
//
// One character at a time, through IDLE, DECODE, FINISH and CLOSE, plus READ
// and EVAL per entry read and PUSH or ERR2 for a push or an error result.
// Every popped entry is read, and so is the entry that stops an operator from
// popping. The read cost comes from the registered read port of the stack
// memory. Results of a character are released once the next one is known, so
// the last one can carry is_last. A stalled output holds the sequencer. Reset
// empties the stack; the stack memory itself needs no clearing.
// ============================================================================
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [itp_pkg::SYM_W-1:0] s_tdata,  // symbol
  input  logic                      s_tlast,  // end_of_expr
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [itp_pkg::SYM_W-1:0] m_tdata,  // out_symbol
  output logic                      m_tlast,  // is_last
  output logic [2:0]                m_tuser   // has_symbol, error_code[1:0]
);
  import itp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  itp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

/* test/testbench.sv */
// ============================================================================
// Infix to postfix converter testbench
// Feeds infix characters through the stream input and compares every postfix
// transaction with an in-bench shunting-yard predictor. A short table of
// directed characters comes first, then random expressions: mostly well formed,
// some broken, some noise, and a few deep nests that overflow the stack.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
  import itp_pkg::*;

  localparam int DIR_N      = 27;
  localparam int RAND_ITEMS = 305;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN      = 100;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             has;
    logic             last;
    err_code_t        err;
  } postfix_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             typed;
    postfix_t         want;
  } dir_row_t;

  localparam postfix_t NO_WANT = '{CHAR_NUL, 1'b0, 1'b0, ERR_NONE};

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{CHAR_A,      1'b1, 1'b1, '{CHAR_A, 1'b1, 1'b1, ERR_NONE}},
    '{CHAR_RPAREN, 1'b1, 1'b1, '{CHAR_NUL, 1'b0, 1'b1, ERR_UNMATCHED}},
    '{8'h31,       1'b1, 1'b1, '{CHAR_NUL, 1'b0, 1'b1, ERR_NONE}},
    '{8'hFF,       1'b1, 1'b1, '{CHAR_NUL, 1'b0, 1'b1, ERR_NONE}},
    '{CHAR_NUL,    1'b1, 1'b1, '{CHAR_NUL, 1'b0, 1'b1, ERR_NONE}},
    '{CHAR_Z,      1'b1, 1'b1, '{CHAR_Z, 1'b1, 1'b1, ERR_NONE}},
    '{CHAR_A,      1'b0, 1'b1, '{CHAR_A, 1'b1, 1'b0, ERR_NONE}},
    '{CHAR_PLUS,   1'b0, 1'b0, NO_WANT},
    '{8'h42,       1'b0, 1'b0, NO_WANT},
    '{CHAR_MUL,    1'b0, 1'b0, NO_WANT},
    '{8'h43,       1'b0, 1'b0, NO_WANT},
    '{CHAR_POW,    1'b0, 1'b0, NO_WANT},
    '{8'h44,       1'b0, 1'b0, NO_WANT},
    '{CHAR_POW,    1'b0, 1'b0, NO_WANT},
    '{8'h45,       1'b0, 1'b0, NO_WANT},
    '{CHAR_MINUS,  1'b0, 1'b0, NO_WANT},
    '{CHAR_LPAREN, 1'b0, 1'b0, NO_WANT},
    '{8'h46,       1'b0, 1'b0, NO_WANT},
    '{CHAR_DIV,    1'b0, 1'b0, NO_WANT},
    '{8'h47,       1'b0, 1'b0, NO_WANT},
    '{CHAR_RPAREN, 1'b0, 1'b0, NO_WANT},
    '{CHAR_LPAREN, 1'b0, 1'b0, NO_WANT},
    '{8'h48,       1'b1, 1'b0, NO_WANT},
    '{8'h4B,       1'b0, 1'b0, NO_WANT},
    '{CHAR_MINUS,  1'b0, 1'b0, NO_WANT},
    '{CHAR_RPAREN, 1'b0, 1'b0, NO_WANT},
    '{8'h78,       1'b1, 1'b1, '{CHAR_NUL, 1'b0, 1'b1, ERR_NONE}}
  };

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [SYM_W-1:0] s_tdata;  // symbol
  logic             s_tlast;  // end_of_expr
  logic             m_tvalid;
  logic             m_tready;
  logic [SYM_W-1:0] m_tdata;  // out_symbol
  logic             m_tlast;  // is_last
  logic [2:0]       m_tuser;  // has_symbol, error_code[1:0]

  infix_to_postfix_converter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  op_code_t         op_stack [STACK_DEPTH];
  int               op_depth;
  postfix_t         postfix_q [$];
  logic [SYM_W-1:0] expr_q [$];

  logic     cur_typed;
  postfix_t cur_want;
  int       burst_left;
  int       idle_cycles;
  int       errors;
  int       n_chars;
  int       n_active;
  int       n_exprs;
  int       n_results;
  int       n_overflow;
  int       n_unmatched;

  function automatic bit is_operator(input logic [SYM_W-1:0] ch);
    return ch == CHAR_PLUS || ch == CHAR_MINUS || ch == CHAR_MUL ||
           ch == CHAR_DIV || ch == CHAR_POW;
  endfunction

  function automatic bit is_active(input logic [SYM_W-1:0] ch);
    return (ch >= CHAR_A && ch <= CHAR_Z) || ch == CHAR_LPAREN ||
           ch == CHAR_RPAREN || is_operator(ch);
  endfunction

  function automatic op_code_t op_of(input logic [SYM_W-1:0] ch);
    case (ch)
      CHAR_PLUS:  return OPC_PLUS;
      CHAR_MINUS: return OPC_MINUS;
      CHAR_MUL:   return OPC_MUL;
      CHAR_DIV:   return OPC_DIV;
      default:    return OPC_POW;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] glyph_of(input op_code_t op);
    case (op)
      OPC_PLUS:  return CHAR_PLUS;
      OPC_MINUS: return CHAR_MINUS;
      OPC_MUL:   return CHAR_MUL;
      OPC_DIV:   return CHAR_DIV;
      OPC_POW:   return CHAR_POW;
      default:   return CHAR_LPAREN;
    endcase
  endfunction

  function automatic int rank_of(input op_code_t op);
    case (op)
      OPC_PLUS, OPC_MINUS: return 1;
      OPC_MUL, OPC_DIV:    return 2;
      OPC_POW:             return 3;
      default:             return 0;
    endcase
  endfunction

  function automatic void add_postfix(input logic [SYM_W-1:0] sym, input logic has,
                                      input err_code_t err);
    postfix_q.push_back('{sym, has, 1'b0, err});
  endfunction

  function automatic void pop_operator();
    op_code_t top;
    top = op_stack[op_depth-1];
    op_depth--;
    if (top != OPC_LPAREN) add_postfix(glyph_of(top), 1'b1, ERR_NONE);
  endfunction

  function automatic void push_operator(input op_code_t op);
    if (op_depth >= STACK_DEPTH) begin
      add_postfix(CHAR_NUL, 1'b0, ERR_OVERFLOW);
    end else begin
      op_stack[op_depth] = op;
      op_depth++;
    end
  endfunction

  function automatic void convert_char(input logic [SYM_W-1:0] ch, input logic last);
    int base;
    int rank;
    base = postfix_q.size();
    if (ch >= CHAR_A && ch <= CHAR_Z) begin
      add_postfix(ch, 1'b1, ERR_NONE);
    end else if (ch == CHAR_LPAREN) begin
      push_operator(OPC_LPAREN);
    end else if (ch == CHAR_RPAREN) begin
      while (op_depth > 0 && op_stack[op_depth-1] != OPC_LPAREN) pop_operator();
      if (op_depth > 0) op_depth--;
      else add_postfix(CHAR_NUL, 1'b0, ERR_UNMATCHED);
    end else if (is_operator(ch)) begin
      rank = rank_of(op_of(ch));
      while (op_depth > 0 && rank_of(op_stack[op_depth-1]) >= rank &&
             op_stack[op_depth-1] != OPC_LPAREN) pop_operator();
      push_operator(op_of(ch));
    end
    if (last) begin
      while (op_depth > 0) pop_operator();
      if (postfix_q.size() == base) add_postfix(CHAR_NUL, 1'b0, ERR_NONE);
      postfix_q[postfix_q.size()-1].last = 1'b1;
    end
  endfunction

  function automatic logic [SYM_W-1:0] rand_letter();
    return CHAR_A + SYM_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [SYM_W-1:0] rand_op();
    case ($urandom_range(0, 4))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_MUL;
      3:       return CHAR_DIV;
      default: return CHAR_POW;
    endcase
  endfunction

  task automatic build_wellformed();
    int terms;
    int open_n;
    terms = $urandom_range(1, 10);
    open_n = 0;
    for (int i = 0; i < terms; i++) begin
      while (open_n < 6 && $urandom_range(0, 3) == 0) begin
        expr_q.push_back(CHAR_LPAREN);
        open_n++;
      end
      expr_q.push_back(rand_letter());
      while (open_n > 0 && $urandom_range(0, 2) == 0) begin
        expr_q.push_back(CHAR_RPAREN);
        open_n--;
      end
      if (i < terms - 1) expr_q.push_back(rand_op());
    end
    while (open_n > 0 && $urandom_range(0, 4) != 0) begin
      expr_q.push_back(CHAR_RPAREN);
      open_n--;
    end
  endtask

  task automatic build_expression();
    int kind;
    int pos;
    kind = $urandom_range(0, 19);
    if (kind <= 15) begin
      build_wellformed();
    end else if (kind <= 17) begin
      build_wellformed();
      pos = $urandom_range(0, expr_q.size() - 1);
      case ($urandom_range(0, 3))
        0:       expr_q[pos] = CHAR_RPAREN;
        1:       expr_q[pos] = CHAR_LPAREN;
        2:       expr_q[pos] = rand_op();
        default: expr_q[pos] = SYM_W'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 1)) expr_q.push_front(CHAR_RPAREN);
    end else if (kind == 18) begin
      repeat ($urandom_range(1, 5)) expr_q.push_back(SYM_W'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(28, 36)) begin
        if ($urandom_range(0, 1)) begin
          expr_q.push_back(rand_letter());
          expr_q.push_back(rand_op());
        end
        expr_q.push_back(CHAR_LPAREN);
      end
      expr_q.push_back(rand_letter());
      repeat ($urandom_range(0, 40)) expr_q.push_back(CHAR_RPAREN);
    end
  endtask

  task automatic send_char(input logic [SYM_W-1:0] ch, input logic last,
                           input logic typed, input postfix_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tlast <= last;
    cur_typed = typed;
    cur_want = want;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
    n_chars++;
    if (is_active(ch)) n_active++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (postfix_q.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : receiver
    int run_left;
    int hold_left;
    run_left = 0;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left = $urandom_range(0, 24);
          hold_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    postfix_t got;
    postfix_t want;
    int base;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata, m_tuser[0], m_tlast, err_code_t'(m_tuser[2:1])};
        n_results++;
        if (postfix_q.size() == 0) begin
          if (errors < 10)
            $display("ERROR: unexpected transaction sym=%h has=%b last=%b err=%0d",
                     got.sym, got.has, got.last, got.err);
          errors++;
        end else begin
          want = postfix_q.pop_front();
          if (want.err == ERR_OVERFLOW) n_overflow++;
          if (want.err == ERR_UNMATCHED) n_unmatched++;
          if (got.sym !== want.sym || got.has !== want.has ||
              got.last !== want.last || got.err !== want.err) begin
            if (errors < 10)
              $display("ERROR: expected sym=%h has=%b last=%b err=%0d, got sym=%h has=%b last=%b err=%0d",
                       want.sym, want.has, want.last, want.err,
                       got.sym, got.has, got.last, got.err);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        base = postfix_q.size();
        convert_char(s_tdata, s_tlast);
        if (cur_typed) begin
          while (postfix_q.size() > base) void'(postfix_q.pop_back());
          postfix_q.push_back(cur_want);
        end
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = CHAR_NUL;
    s_tlast = 1'b0;
    cur_typed = 1'b0;
    cur_want = NO_WANT;
    op_depth = 0;
    burst_left = 0;
    idle_cycles = 0;
    errors = 0;
    n_chars = 0;
    n_active = 0;
    n_exprs = 0;
    n_results = 0;
    n_overflow = 0;
    n_unmatched = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++)
      send_char(DIR_TAB[i].sym, DIR_TAB[i].last, DIR_TAB[i].typed, DIR_TAB[i].want);
    wait_drained();

    while (n_active < DIR_N + RAND_ITEMS) begin
      build_expression();
      for (int i = 0; i < expr_q.size(); i++)
        send_char(expr_q[i], i == expr_q.size() - 1, 1'b0, NO_WANT);
      expr_q.delete();
      n_exprs++;
      if (n_exprs % 12 == 0) wait_drained();
    end

    s_tvalid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d characters in %0d random expressions plus the directed table.",
             n_chars, n_exprs);
    $display("Checked %0d postfix transactions, %0d overflow and %0d unmatched flags.",
             n_results, n_overflow, n_unmatched);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
